// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	typedef enum logic [1:0] {
		PAD_MARK = 2'd0,
		PAD_ZERO = 2'd1,
		PAD_LEN  = 2'd2
	} pad_stage_t;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sg0(input logic [31:0] x);
		sg0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sg1(input logic [31:0] x);
		sg1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bs0(input logic [31:0] x);
		bs0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bs1(input logic [31:0] x);
		bs1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage

// ----- hw/rtl/sha256_if.sv -----
interface sha256_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, mode, data_byte, input ready);
	modport sink (input valid, mode, data_byte, output ready);
endinterface

interface sha256_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hw/rtl/sha256_ram.sv -----
module sha256_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hw/rtl/sha256_byte_stream_hasher.sv -----
// SHA-256 over a byte stream. A request with mode 0 appends data_byte to the
// message; the byte that completes a 64-byte block starts a compression
// (loading the block from the buffer RAM, 64 rounds of the single round unit,
// folding the result back into the chaining RAM), during which no request is
// taken. A request with mode 1 pads the message one byte at a time, pausing
// for each compression, compresses one or two more blocks, then returns the
// eight digest words H0..H7 as eight responses, each read, registered and held
// until taken, and starts a new message.
module sha256_byte_stream_hasher (
	input logic               clk,
	input logic               arst_n,
	sha256_req_if.sink        req,
	sha256_rsp_if.source      rsp
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PAD   = 8'b0000_0010,
		ST_LOAD  = 8'b0000_0100,
		ST_ROUND = 8'b0000_1000,
		ST_FINAL = 8'b0001_0000,
		ST_ORD   = 8'b0010_0000,
		ST_OWR   = 8'b0100_0000,
		ST_OWAIT = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	sha256_pkg::pad_stage_t pad_q;
	logic [5:0]             cnt_q;
	logic [63:0]            len_q;
	logic [23:0]            wacc_q;
	logic [4:0]             c_q;
	logic [5:0]             rnd_q;
	logic [2:0]             oc_q;
	logic                   fin_q;
	logic                   last_q;
	logic [7:0]             hv_q;
	logic [2:0]             h_ra_s1;
	logic [31:0]            v_q [8];
	logic [31:0]            w_q [16];
	logic                   out_valid_q;
	logic [31:0]            out_word_q;
	logic [2:0]             out_idx_q;
	logic                   out_last_q;

	logic        push;
	logic [7:0]  push_byte;
	logic        buf_we;
	logic [31:0] buf_rdata;
	logic        h_we;
	logic [2:0]  h_waddr;
	logic [31:0] h_wdata;
	logic [2:0]  h_raddr;
	logic [31:0] h_rdata;
	logic [31:0] h_rd;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.digest_word = out_word_q;
	assign rsp.word_index  = out_idx_q;
	assign rsp.last_word   = out_last_q;

	always_comb begin
		push      = 1'b0;
		push_byte = req.data_byte;
		if (state_q == ST_IDLE) begin
			push = req.valid && (req.mode == sha256_pkg::MODE_ABSORB);
		end else if (state_q == ST_PAD) begin
			case (pad_q)
				sha256_pkg::PAD_MARK: begin
					push      = 1'b1;
					push_byte = 8'h80;
				end
				sha256_pkg::PAD_ZERO: begin
					push      = (cnt_q != 6'd56);
					push_byte = 8'h00;
				end
				sha256_pkg::PAD_LEN: begin
					push      = 1'b1;
					push_byte = len_q[63:56];
				end
				default: begin
					push      = 1'b0;
					push_byte = 8'h00;
				end
			endcase
		end
	end

	assign buf_we = push && (cnt_q[1:0] == 2'd3);

	sha256_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q[5:2]),
		.wdata ({wacc_q, push_byte}),
		.raddr (c_q[3:0]),
		.rdata (buf_rdata)
	);

	assign h_raddr = (state_q == ST_ORD || state_q == ST_OWR || state_q == ST_OWAIT)
		? oc_q : c_q[2:0];
	assign h_we    = (state_q == ST_FINAL) && (c_q != 5'd0);
	assign h_waddr = 3'(c_q - 5'd1);
	assign h_rd    = hv_q[h_ra_s1] ? h_rdata : sha256_pkg::INIT_H[h_ra_s1];
	assign h_wdata = h_rd + v_q[0];

	sha256_ram #(.WIDTH(32), .DEPTH(8)) u_chain (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	always_comb begin
		t1 = v_q[7] + sha256_pkg::bs1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256_pkg::ROUND_K[rnd_q] + w_q[0];
		t2 = sha256_pkg::bs0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + sha256_pkg::sg0(w_q[1]) + w_q[9] + sha256_pkg::sg1(w_q[14]);
	end

	always_ff @(posedge clk) begin
		h_ra_s1 <= h_raddr;
		if (push)
			wacc_q <= {wacc_q[15:0], push_byte};
		if (state_q == ST_LOAD && c_q != 5'd0) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= buf_rdata;
			if (c_q <= 5'd8) begin
				for (int i = 0; i < 7; i++)
					v_q[i] <= v_q[i+1];
				v_q[7] <= h_rd;
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end else if (state_q == ST_FINAL && c_q != 5'd0) begin
			for (int i = 0; i < 7; i++)
				v_q[i] <= v_q[i+1];
			v_q[7] <= v_q[0];
		end
		if (state_q == ST_OWR) begin
			out_word_q <= h_rd;
			out_idx_q  <= oc_q;
			out_last_q <= (oc_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pad_q       <= sha256_pkg::PAD_MARK;
			cnt_q       <= '0;
			len_q       <= '0;
			c_q         <= '0;
			rnd_q       <= '0;
			oc_q        <= '0;
			fin_q       <= 1'b0;
			last_q      <= 1'b0;
			hv_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push)
				cnt_q <= cnt_q + 6'd1;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						if (req.mode == sha256_pkg::MODE_FINISH) begin
							fin_q   <= 1'b1;
							state_q <= ST_PAD;
						end else begin
							len_q <= len_q + 64'd8;
							if (cnt_q == 6'd63) begin
								c_q     <= '0;
								state_q <= ST_LOAD;
							end
						end
					end
				end
				ST_PAD: begin
					case (pad_q)
						sha256_pkg::PAD_MARK: pad_q <= sha256_pkg::PAD_ZERO;
						sha256_pkg::PAD_ZERO: begin
							if (cnt_q == 6'd56)
								pad_q <= sha256_pkg::PAD_LEN;
						end
						sha256_pkg::PAD_LEN: begin
							len_q <= {len_q[55:0], 8'h00};
							if (cnt_q == 6'd63)
								last_q <= 1'b1;
						end
						default: pad_q <= sha256_pkg::PAD_MARK;
					endcase
					if (push && cnt_q == 6'd63) begin
						c_q     <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					c_q <= c_q + 5'd1;
					if (c_q == 5'd16) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						c_q     <= '0;
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					c_q <= c_q + 5'd1;
					if (c_q != 5'd0)
						hv_q[h_waddr] <= 1'b1;
					if (c_q == 5'd8) begin
						if (last_q) begin
							oc_q    <= '0;
							state_q <= ST_ORD;
						end else if (fin_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ORD: state_q <= ST_OWR;
				ST_OWR: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						oc_q        <= oc_q + 3'd1;
						if (oc_q == 3'd7) begin
							hv_q    <= '0;
							len_q   <= '0;
							fin_q   <= 1'b0;
							last_q  <= 1'b0;
							pad_q   <= sha256_pkg::PAD_MARK;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while digest pending");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last_word) |-> (rsp.word_index == 3'd7))
		else $error("last word flag on wrong index");

	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (cnt_q == 6'd0))
		else $error("buffer not empty during compression");

	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && rsp.last_word) |=> (hv_q == 8'd0 && len_q == 64'd0))
		else $error("state not reinitialized after digest");
endmodule

// ----- dv/sha256_checker.sv -----
`timescale 1ns / 100ps

module sha256_checker (
	input logic          clk,
	input logic          arst_n,
	sha256_req_if.sink   req,
	sha256_rsp_if.sink   rsp,
	output int           fail_count,
	output int           words_pending,
	output int           digests_seen
);
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_out_t;

	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	int unsigned fill;
	logic [63:0] bit_total;
	digest_out_t digest_q [$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic push_byte(input logic [7:0] b);
		msg_block[fill] = b;
		fill++;
		if (fill == 64) begin
			compress_block();
			fill = 0;
		end
	endtask

	task automatic predict_request(input logic m, input logic [7:0] b);
		logic [63:0] len;
		digest_out_t d;
		if (m == sha256_pkg::MODE_ABSORB) begin
			bit_total += 64'd8;
			push_byte(b);
		end else begin
			len = bit_total;
			push_byte(8'h80);
			while (fill != 56)
				push_byte(8'h00);
			for (int i = 0; i < 8; i++)
				push_byte(len[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				d.digest_word = hash_state[i];
				d.word_index = 3'(i);
				d.last_word = (i == 7);
				digest_q = {digest_q, d};
			end
			for (int i = 0; i < 8; i++)
				hash_state[i] = sha256_pkg::INIT_H[i];
			fill = 0;
			bit_total = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_out_t e;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				hash_state[i] = sha256_pkg::INIT_H[i];
			fill = 0;
			bit_total = '0;
			digest_q = {};
			fail_count = 0;
			digests_seen = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", rsp.digest_word);
					fail_count++;
				end else begin
					e = digest_q.pop_front();
					if (rsp.digest_word !== e.digest_word) begin
						$error("digest_word exp %h got %h", e.digest_word, rsp.digest_word);
						fail_count++;
					end
					if (rsp.word_index !== e.word_index) begin
						$error("word_index exp %0d got %0d", e.word_index, rsp.word_index);
						fail_count++;
					end
					if (rsp.last_word !== e.last_word) begin
						$error("last_word exp %0d got %0d", e.last_word, rsp.last_word);
						fail_count++;
					end
					if (e.last_word)
						digests_seen++;
				end
			end
			if (req.valid && req.ready)
				predict_request(req.mode, req.data_byte);
		end
		words_pending = digest_q.size();
	end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, words_pending, digests_seen;
	int   n_bytes = 0;
	logic ok;

	sha256_req_if req ();
	sha256_rsp_if rsp ();

	sha256_byte_stream_hasher i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	sha256_checker i_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .words_pending(words_pending),
		.digests_seen(digests_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	// ready only moves at rising edges, so its value at a falling edge
	// decides the next rising edge
	task automatic send_request(input logic m, input logic [7:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.data_byte <= b;
		while (!req.ready)
			@(negedge clk);
		@(negedge clk);
		if (m == sha256_pkg::MODE_ABSORB)
			n_bytes++;
	endtask

	task automatic send_message(input int len, input int kind);
		for (int i = 0; i < len; i++)
			send_request(sha256_pkg::MODE_ABSORB,
				kind == 1 ? 8'h00 : kind == 2 ? 8'hff : 8'($urandom));
		send_request(sha256_pkg::MODE_FINISH, 8'($urandom));
	endtask

	// sink stalls: phases of free flow and random backpressure
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				repeat ($urandom_range(10, 40)) @(negedge clk);
			rsp.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
		end
	end

	initial begin
		req.valid = 1'b0;
		req.mode = sha256_pkg::MODE_ABSORB;
		req.data_byte = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, padding boundaries, extreme bytes
		send_message(0, 0);
		send_message(0, 0);
		send_message(3, 2);
		send_message(55, 1);
		send_message(56, 2);
		send_message(63, 0);
		send_message(64, 0);
		send_message(1, 1);

		while (n_bytes < 400) begin
			if ($urandom_range(0, 4) == 0)
				send_message($urandom_range(50, 130), 0);
			else
				send_message($urandom_range(0, 20), 0);
		end
		req.valid <= 1'b0;

		while (words_pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		ok = (fail_count == 0);
		$display("%0d digests over %0d message bytes checked", digests_seen, n_bytes);
		if (ok)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_if.sv
hw/rtl/sha256_ram.sv
hw/rtl/sha256_byte_stream_hasher.sv
dv/sha256_checker.sv
dv/tb.sv
